// File: hw/rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared widths, status codes and sequencer states for the stereo linear
// resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

  // payload widths
  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 16;
  localparam int STEP_W    = 20;
  localparam int OUTCNT_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int FRAME_W   = 2 * SAMPLE_W;

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_OUT_FRAMES = 1'b1;
  localparam logic [STEP_W-1:0]   PHASE_STEP_RST = 20'h10000;
  localparam logic [OUTCNT_W-1:0] OUT_FRAMES_RST = 16'h0000;

  // fixed point
  localparam int FRAC_W    = 16;
  localparam int WEIGHT_W  = FRAC_W + 1;
  localparam int POS_INT_W = INDEX_W + STEP_W - FRAC_W;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // shared multiplier operands (signed, wide enough for both uses)
  localparam int MUL_A_W   = STEP_W + 1;
  localparam int MUL_B_W   = DIFF_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MIX_Q_W   = PROD_W - FRAC_W;
  localparam logic signed [MIX_Q_W-1:0] SAT_HI = 23'sd32767;
  localparam logic signed [MIX_Q_W-1:0] SAT_LO = -23'sd32768;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // request sequencer
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POS  = 7'b0000010,
    S_ADDR = 7'b0000100,
    S_RDB  = 7'b0001000,
    S_MULL = 7'b0010000,
    S_MULR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/slr_ifs.sv
// ----------------------------------------------------------------------------
// slr channel interfaces
// Valid/ready channels for source items and result items.
// ----------------------------------------------------------------------------
interface slr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic                                first_frame;
  logic signed [slr_pkg::SAMPLE_W-1:0] left_in;
  logic signed [slr_pkg::SAMPLE_W-1:0] right_in;
  logic        [slr_pkg::INDEX_W-1:0]  out_index;

  modport source (output valid, mode, first_frame, left_in, right_in, out_index,
                  input ready);
  modport sink   (input valid, mode, first_frame, left_in, right_in, out_index,
                  output ready);
endinterface

interface slr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [slr_pkg::SAMPLE_W-1:0] left_out;
  logic signed [slr_pkg::SAMPLE_W-1:0] right_out;
  logic        [slr_pkg::STATUS_W-1:0] status;

  modport source (output valid, left_out, right_out, status, input ready);
  modport sink   (input valid, left_out, right_out, status, output ready);
endinterface

// File: hw/rtl/slr_mul.sv
// ----------------------------------------------------------------------------
// slr_mul
// Shared signed multiplier with a registered product, used for the source
// position and for both channel weights.
// ----------------------------------------------------------------------------
module slr_mul (
  input  logic                              clk,
  input  logic signed [slr_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [slr_pkg::MUL_B_W-1:0] op_b,
  output logic signed [slr_pkg::PROD_W-1:0]  prod
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// File: hw/rtl/stereo_linear_resampler_top.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top
// Stereo source frame store with linear interpolation of output frames.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one item per transfer. mode 0 loads a stereo frame into the
//   store (first_frame restarts it at entry zero; frames past capacity are
//   dropped). mode 1 requests output frame out_index; each request gives one
//   result transfer on dst, loads give none.
//   The APB port sets phase_step (0x0, Q4.16) and out_frames (0x4).
// Sequencing:
//   a load is taken in idle without leaving it. An erroneous request shows
//   its result at the next edge. A good request runs through the sequencer
//   states S_POS, S_ADDR, S_RDB, S_MULL, S_MULR and S_DONE, and src takes
//   no next item until the sequencer is back in idle: one shared 21x18
//   multiplier is used three times (position, left weight, right weight) and
//   the single store read port fetches the two neighbor frames one after the other.
// Reset:
//   frame count clears, phase_step returns to 1.0, out_frames to 0. The
//   store contents stay undefined; there is no clearing pass.
// Stall:
//   a result waits in the output register; src is ready in idle whenever
//   that register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_top #(
  parameter int MAX_SRC_FRAMES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  slr_in_if.sink                        src,
  slr_out_if.source                     dst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slr_pkg::PADDR_W-1:0]   paddr,
  input  logic [slr_pkg::PDATA_W-1:0]   pwdata,
  output logic [slr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_SRC_FRAMES);
  localparam int CW = $clog2(MAX_SRC_FRAMES + 1);

  // configuration registers
  logic [slr_pkg::STEP_W-1:0]   phase_step;
  logic [slr_pkg::OUTCNT_W-1:0] out_frames;

  // control state
  slr_pkg::state_t state;
  logic [CW-1:0]   frame_count;
  logic            out_valid;

  // payload registers
  logic [slr_pkg::INDEX_W-1:0]         idx;
  logic [AW-1:0]                       base_addr;
  logic [slr_pkg::WEIGHT_W-1:0]        weight;
  logic [slr_pkg::FRAME_W-1:0]         frame_a;
  logic signed [slr_pkg::DIFF_W-1:0]   diff_r;
  logic signed [slr_pkg::SAMPLE_W-1:0] left_res;
  logic signed [slr_pkg::SAMPLE_W-1:0] out_left;
  logic signed [slr_pkg::SAMPLE_W-1:0] out_right;
  logic [slr_pkg::STATUS_W-1:0]        out_status;

  // frame store
  logic [slr_pkg::FRAME_W-1:0] mem [MAX_SRC_FRAMES];
  logic [slr_pkg::FRAME_W-1:0] rd_data;
  logic [AW-1:0]               rd_addr;

  // combinational helpers
  logic                               load_xfer;
  logic                               req_xfer;
  logic [CW-1:0]                      count_base;
  logic                               store_ok;
  logic                               few_frames;
  logic                               bad_index;
  logic [slr_pkg::POS_INT_W-1:0]      ipos;
  logic [slr_pkg::POS_INT_W-1:0]      last_idx;
  logic                               past_end;
  logic [AW-1:0]                      base_next;
  logic [slr_pkg::WEIGHT_W-1:0]       weight_next;
  logic signed [slr_pkg::DIFF_W-1:0]  diff_l;
  logic signed [slr_pkg::DIFF_W-1:0]  diff_r_next;
  logic signed [slr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [slr_pkg::MUL_B_W-1:0] mul_b;
  logic signed [slr_pkg::PROD_W-1:0]  prod;

  // a + p / 65536 with truncation toward zero, saturated to int16
  function automatic logic signed [slr_pkg::SAMPLE_W-1:0] mix_round(
    input logic signed [slr_pkg::SAMPLE_W-1:0] a,
    input logic signed [slr_pkg::PROD_W-1:0]   p
  );
    logic signed [slr_pkg::PROD_W-1:0]  num;
    logic signed [slr_pkg::MIX_Q_W-1:0] q;
    num = (slr_pkg::PROD_W'(a) <<< slr_pkg::FRAC_W) + p;
    q   = num[slr_pkg::PROD_W-1:slr_pkg::FRAC_W];
    if (num[slr_pkg::PROD_W-1] && (num[slr_pkg::FRAC_W-1:0] != '0)) begin
      q = q + slr_pkg::MIX_Q_W'(1);
    end
    if (q > slr_pkg::SAT_HI) begin
      q = slr_pkg::SAT_HI;
    end else if (q < slr_pkg::SAT_LO) begin
      q = slr_pkg::SAT_LO;
    end
    return q[slr_pkg::SAMPLE_W-1:0];
  endfunction

  // apb register access
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      slr_pkg::REG_PHASE_STEP: prdata = slr_pkg::PDATA_W'(phase_step);
      slr_pkg::REG_OUT_FRAMES: prdata = slr_pkg::PDATA_W'(out_frames);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= slr_pkg::PHASE_STEP_RST;
      out_frames <= slr_pkg::OUT_FRAMES_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        slr_pkg::REG_PHASE_STEP: phase_step <= pwdata[slr_pkg::STEP_W-1:0];
        slr_pkg::REG_OUT_FRAMES: out_frames <= pwdata[slr_pkg::OUTCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign src.ready = (state == slr_pkg::S_IDLE) && (!out_valid || dst.ready);
  assign load_xfer = src.valid && src.ready && !src.mode;
  assign req_xfer  = src.valid && src.ready && src.mode;

  // load path: restart or append, drop when full
  assign count_base = src.first_frame ? '0 : frame_count;
  assign store_ok   = count_base < CW'(MAX_SRC_FRAMES);

  // request error checks
  assign few_frames = frame_count < CW'(2);
  assign bad_index  = src.out_index >= out_frames;

  // position split and end clamp
  assign ipos        = prod[slr_pkg::FRAC_W +: slr_pkg::POS_INT_W];
  assign last_idx    = slr_pkg::POS_INT_W'(frame_count) - slr_pkg::POS_INT_W'(1);
  assign past_end    = ipos >= last_idx;
  assign base_next   = past_end ? AW'(frame_count - CW'(2)) : ipos[AW-1:0];
  assign weight_next = past_end ? slr_pkg::WEIGHT_ONE
                                : {1'b0, prod[slr_pkg::FRAC_W-1:0]};

  // channel differences b - a, with rd_data holding frame b
  assign diff_l = slr_pkg::DIFF_W'($signed(rd_data[slr_pkg::FRAME_W-1:slr_pkg::SAMPLE_W]))
                - slr_pkg::DIFF_W'($signed(frame_a[slr_pkg::FRAME_W-1:slr_pkg::SAMPLE_W]));
  assign diff_r_next = slr_pkg::DIFF_W'($signed(rd_data[slr_pkg::SAMPLE_W-1:0]))
                     - slr_pkg::DIFF_W'($signed(frame_a[slr_pkg::SAMPLE_W-1:0]));

  // multiplier operand select
  always_comb begin
    case (state)
      slr_pkg::S_POS: begin
        mul_a = $signed({1'b0, phase_step});
        mul_b = $signed({2'b00, idx});
      end
      slr_pkg::S_MULL: begin
        mul_a = $signed({4'b0000, weight});
        mul_b = slr_pkg::MUL_B_W'(diff_l);
      end
      slr_pkg::S_MULR: begin
        mul_a = $signed({4'b0000, weight});
        mul_b = slr_pkg::MUL_B_W'(diff_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  slr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // store read address: frame a, then frame a + 1
  always_comb begin
    case (state)
      slr_pkg::S_ADDR: rd_addr = base_next;
      slr_pkg::S_RDB:  rd_addr = base_addr + AW'(1);
      default:         rd_addr = base_addr;
    endcase
  end

  // frame store write and registered read
  always_ff @(posedge clk) begin
    if (load_xfer && store_ok) begin
      mem[count_base[AW-1:0]] <= {src.left_in, src.right_in};
    end
    rd_data <= mem[rd_addr];
  end

  // frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (load_xfer) begin
      if (store_ok) begin
        frame_count <= count_base + CW'(1);
      end else begin
        frame_count <= count_base;
      end
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::S_IDLE;
    end else begin
      case (state)
        slr_pkg::S_IDLE: begin
          if (req_xfer && !few_frames && !bad_index) begin
            state <= slr_pkg::S_POS;
          end
        end
        slr_pkg::S_POS:  state <= slr_pkg::S_ADDR;
        slr_pkg::S_ADDR: state <= slr_pkg::S_RDB;
        slr_pkg::S_RDB:  state <= slr_pkg::S_MULL;
        slr_pkg::S_MULL: state <= slr_pkg::S_MULR;
        slr_pkg::S_MULR: state <= slr_pkg::S_DONE;
        slr_pkg::S_DONE: state <= slr_pkg::S_IDLE;
        default:         state <= slr_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers along the sequence
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      idx <= src.out_index;
    end
    if (state == slr_pkg::S_ADDR) begin
      base_addr <= base_next;
      weight    <= weight_next;
    end
    if (state == slr_pkg::S_RDB) begin
      frame_a <= rd_data;
    end
    if (state == slr_pkg::S_MULL) begin
      diff_r <= diff_r_next;
    end
    if (state == slr_pkg::S_MULR) begin
      left_res <= mix_round($signed(frame_a[slr_pkg::FRAME_W-1:slr_pkg::SAMPLE_W]), prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_xfer && (few_frames || bad_index)) begin
      out_valid <= 1'b1;
    end else if (state == slr_pkg::S_DONE) begin
      out_valid <= 1'b1;
    end else if (out_valid && dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer && few_frames) begin
      out_left   <= '0;
      out_right  <= '0;
      out_status <= slr_pkg::STATUS_FEW;
    end else if (req_xfer && bad_index) begin
      out_left   <= '0;
      out_right  <= '0;
      out_status <= slr_pkg::STATUS_RANGE;
    end else if (state == slr_pkg::S_DONE) begin
      out_left   <= left_res;
      out_right  <= mix_round($signed(frame_a[slr_pkg::SAMPLE_W-1:0]), prod);
      out_status <= slr_pkg::STATUS_OK;
    end
  end

  assign dst.valid     = out_valid;
  assign dst.left_out  = out_left;
  assign dst.right_out = out_right;
  assign dst.status    = out_status;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CW'(MAX_SRC_FRAMES))
    else $error("frame count above store capacity");

  a_load_append: assert property (@(posedge clk) disable iff (rst)
    load_xfer && !src.first_frame && (frame_count < CW'(MAX_SRC_FRAMES))
    |=> frame_count == $past(frame_count) + CW'(1))
    else $error("appended load did not advance frame count");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != slr_pkg::STATUS_OK)
    |-> (out_left == '0) && (out_right == '0))
    else $error("error result carries nonzero samples");

  a_req_latency: assert property (@(posedge clk) disable iff (rst)
    req_xfer && !few_frames && !bad_index |-> ##7 out_valid)
    else $error("good request produced no result in time");

endmodule
